// ----- src/htsa_pkg.sv -----
// Shared constants, register codes and types for the tile swizzle address block.
// No dependencies; imported by every other file in src.
package htsa_pkg;

  localparam int COORD_BITS     = 14;
  localparam int INDEX_BITS     = 28;
  localparam int MAX_LEVELS     = 6;

  // configuration register widths
  localparam int COLS_BITS      = 15;
  localparam int LVL_CNT_BITS   = 3;
  localparam int FACTOR_BITS    = 12;
  localparam int ORDER_BITS     = 6;
  localparam int LEAF_BITS      = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 15;

  // per-level factor log2 is 1..4, digit half is at most 4 bits
  localparam int LF_BITS        = 3;
  localparam int DIGIT_BITS     = 4;

  localparam int SUM_BITS       = $clog2(4 * MAX_LEVELS + 1);
  localparam int LBITS_BITS     = $clog2(8 * MAX_LEVELS + 1);
  localparam int MLOG_BITS      = $clog2(7 + 4 * MAX_LEVELS + 1);
  localparam int LVL_IDX_BITS   = $clog2(MAX_LEVELS + 1);
  localparam int FC_EXT         = (2 * MAX_LEVELS > FACTOR_BITS) ? 2 * MAX_LEVELS : FACTOR_BITS;
  localparam int ORD_EXT        = (MAX_LEVELS > ORDER_BITS) ? MAX_LEVELS : ORDER_BITS;

  // input register, digit extract, digit placement, one divider stage per index bit
  localparam int PIPE_DEPTH     = INDEX_BITS + 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MACRO_COLS   = 0,
    CFG_LEVEL_COUNT  = 1,
    CFG_FACTOR_CODES = 2,
    CFG_LEVEL_ORDERS = 3,
    CFG_LEAF_LOG2    = 4
  } cfg_reg_t;

  typedef struct packed {
    logic [COLS_BITS-1:0]    macro_cols;
    logic [LVL_CNT_BITS-1:0] level_count;
    logic [FACTOR_BITS-1:0]  level_factor_codes;
    logic [ORDER_BITS-1:0]   level_orders;
    logic [LEAF_BITS-1:0]    leaf_size_log2;
  } cfg_regs_t;

  typedef struct packed {
    logic [COLS_BITS-1:0]                    cols;
    logic [LEAF_BITS-1:0]                    leaf;
    logic [SUM_BITS-1:0]                     sum_lf;
    logic [LBITS_BITS-1:0]                   lbits;
    logic [MLOG_BITS-1:0]                    macro_log;
    logic [MAX_LEVELS-1:0]                   active;
    logic [MAX_LEVELS-1:0]                   z_order;
    logic [MAX_LEVELS-1:0][LF_BITS-1:0]      lf;
    logic [MAX_LEVELS-1:0][LBITS_BITS-1:0]   rem_bits;
    logic [MAX_LEVELS-1:0][MLOG_BITS-1:0]    sub_log;
  } lvl_cfg_t;

endpackage

// ----- src/hierarchical_tile_swizzle_address.sv -----
// Top level: leaf tile index to destination and raster source pixel positions.
// Depends on htsa_pkg and htsa_cfg_decode.
// Throughput: one beat per cycle unless out_stall holds back a full pipeline; the depth
// comes from the radix-2 divider by the macro column count, one quotient bit per stage,
// two lanes side by side.
// Reset (synchronous): clears all valid bits and loads the register reset values.
module hierarchical_tile_swizzle_address import htsa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [INDEX_BITS-1:0]     leaf_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COORD_BITS-1:0]     dest_x,
  output logic [COORD_BITS-1:0]     dest_y,
  output logic [COORD_BITS-1:0]     src_x,
  output logic [COORD_BITS-1:0]     src_y
);

  typedef struct packed {
    logic [INDEX_BITS-1:0] num;
    logic [COLS_BITS-1:0]  rem;
    logic [COORD_BITS-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t                               m;
    lane_t                               n;
    logic [MAX_LEVELS-1:0][DIGIT_BITS-1:0] hi;
    logic [MAX_LEVELS-1:0][DIGIT_BITS-1:0] lo;
    logic [COORD_BITS-1:0]               dd_x;
    logic [COORD_BITS-1:0]               dd_y;
    logic [COORD_BITS-1:0]               src_lo;
  } pipe_t;

  cfg_regs_t             regs;
  lvl_cfg_t              dec;
  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH:0]   rdy;
  logic [INDEX_BITS-1:0] idx0;
  pipe_t                 st  [1:PIPE_DEPTH-1];
  pipe_t                 nxt [1:PIPE_DEPTH-1];
  logic [COORD_BITS-1:0] dest_x_next, dest_y_next, src_x_next, src_y_next;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{macro_cols: COLS_BITS'(1), level_count: '0, level_factor_codes: '0,
                level_orders: '0, leaf_size_log2: '0};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MACRO_COLS:   regs.macro_cols         <= cfg_data[COLS_BITS-1:0];
        CFG_LEVEL_COUNT:  regs.level_count        <= cfg_data[LVL_CNT_BITS-1:0];
        CFG_FACTOR_CODES: regs.level_factor_codes <= cfg_data[FACTOR_BITS-1:0];
        CFG_LEVEL_ORDERS: regs.level_orders       <= cfg_data[ORDER_BITS-1:0];
        CFG_LEAF_LOG2:    regs.leaf_size_log2     <= cfg_data[LEAF_BITS-1:0];
        default: ;
      endcase
    end
  end

  htsa_cfg_decode u_dec (
    .regs (regs),
    .dec  (dec)
  );

  // ---------------------------------------------------------------- stage functions
  // split the index: divider dividends, source low bits, per-level digit halves
  function automatic pipe_t stage_split(logic [INDEX_BITS-1:0] idx, lvl_cfg_t c);
    logic [INDEX_BITS-1:0] low;
    logic [INDEX_BITS-1:0] d;
    logic [INDEX_BITS-1:0] dsh;
    logic [DIGIT_BITS-1:0] mask;
    pipe_t                 p;
    p       = '0;
    p.m.num = idx >> c.lbits;
    p.n.num = idx >> c.sum_lf;
    low     = idx & ~({INDEX_BITS{1'b1}} << c.sum_lf);
    p.src_lo = COORD_BITS'(low) << c.leaf;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      d    = idx >> c.rem_bits[i];
      dsh  = d >> c.lf[i];
      mask = ~({DIGIT_BITS{1'b1}} << c.lf[i]);
      if (c.active[i]) begin
        p.lo[i] = d[DIGIT_BITS-1:0] & mask;
        p.hi[i] = dsh[DIGIT_BITS-1:0] & mask;
      end
    end
    return p;
  endfunction

  // place each digit half at its level's offset; levels never overlap, so OR
  function automatic pipe_t stage_place(pipe_t a, lvl_cfg_t c);
    logic [COORD_BITS-1:0] hx;
    logic [COORD_BITS-1:0] lx;
    pipe_t                 p;
    p      = a;
    p.dd_x = '0;
    p.dd_y = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      hx = COORD_BITS'(a.hi[i]) << c.sub_log[i];
      lx = COORD_BITS'(a.lo[i]) << c.sub_log[i];
      if (c.z_order[i]) begin
        p.dd_y = p.dd_y | hx;
        p.dd_x = p.dd_x | lx;
      end else begin
        p.dd_x = p.dd_x | hx;
        p.dd_y = p.dd_y | lx;
      end
    end
    return p;
  endfunction

  // one restoring division step; only the low quotient bits survive the coord wrap
  function automatic lane_t div_step(lane_t a, logic [COLS_BITS-1:0] dv);
    logic [COLS_BITS:0] trial;
    logic               ge;
    lane_t              r;
    trial = {a.rem, a.num[INDEX_BITS-1]};
    ge    = (trial >= {1'b0, dv});
    r.num = a.num << 1;
    r.rem = ge ? COLS_BITS'(trial - {1'b0, dv}) : COLS_BITS'(trial);
    r.quo = {a.quo[COORD_BITS-2:0], ge};
    return r;
  endfunction

  assign nxt[1] = stage_split(idx0, dec);
  assign nxt[2] = stage_place(st[1], dec);

  for (genvar k = 0; k < INDEX_BITS; k++) begin : g_div
    assign nxt[3+k] = '{m: div_step(st[2+k].m, dec.cols), n: div_step(st[2+k].n, dec.cols),
                        hi: st[2+k].hi, lo: st[2+k].lo, dd_x: st[2+k].dd_x,
                        dd_y: st[2+k].dd_y, src_lo: st[2+k].src_lo};
  end

  // ---------------------------------------------------------------- flow control
  // a stage may load when it or any stage downstream of it is empty, or the output moves
  assign rdy[PIPE_DEPTH] = !out_valid || !out_stall;
  for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_rdy
    assign rdy[k] = rdy[PIPE_DEPTH] || !(&v[PIPE_DEPTH-1:k]);
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (rdy[PIPE_DEPTH]) begin
        out_valid <= v[PIPE_DEPTH-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      idx0 <= leaf_index;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (rdy[k]) begin
        st[k] <= nxt[k];
      end
    end
    if (rdy[PIPE_DEPTH]) begin
      dest_x <= dest_x_next;
      dest_y <= dest_y_next;
      src_x  <= src_x_next;
      src_y  <= src_y_next;
    end
  end

  // ---------------------------------------------------------------- result
  // macro block offset sits above every digit, source remainder above the low bits
  assign dest_x_next = (COORD_BITS'(st[PIPE_DEPTH-1].m.rem) << dec.macro_log)
                       + st[PIPE_DEPTH-1].dd_x;
  assign dest_y_next = (COORD_BITS'(st[PIPE_DEPTH-1].m.quo) << dec.macro_log)
                       + st[PIPE_DEPTH-1].dd_y;
  assign src_x_next  = (COORD_BITS'(st[PIPE_DEPTH-1].n.rem) << dec.macro_log)
                       + st[PIPE_DEPTH-1].src_lo;
  assign src_y_next  = COORD_BITS'(st[PIPE_DEPTH-1].n.quo) << dec.leaf;

  // ---------------------------------------------------------------- checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && (&v)))
    else $error("input stalled while the pipeline has room");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && (v == '0)))
    else $error("valid bits survive reset");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v[PIPE_DEPTH-1]))
    else $error("result beat without a beat in the last stage");

endmodule

// ----- src/htsa_cfg_decode.sv -----
// Decodes the configuration registers into per-level shift amounts and totals.
// Depends on htsa_pkg.
module htsa_cfg_decode import htsa_pkg::*; (
  input  cfg_regs_t regs,
  output lvl_cfg_t  dec
);

  logic [FC_EXT-1:0]       codes;
  logic [ORD_EXT-1:0]      ords;
  logic [LVL_IDX_BITS-1:0] levels;
  logic [SUM_BITS-1:0]     acc;
  logic [LF_BITS-1:0]      f;

  always_comb begin
    codes  = FC_EXT'(regs.level_factor_codes);
    ords   = ORD_EXT'(regs.level_orders);
    levels = (regs.level_count > MAX_LEVELS) ? LVL_IDX_BITS'(MAX_LEVELS)
                                             : LVL_IDX_BITS'(regs.level_count);
    dec      = '0;
    dec.cols = (regs.macro_cols == '0) ? COLS_BITS'(1) : regs.macro_cols;
    dec.leaf = regs.leaf_size_log2;
    acc      = '0;
    f        = '0;
    // innermost level first so acc holds the bits below the current level
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      f               = LF_BITS'(codes[2*i +: 2]) + LF_BITS'(1);
      dec.lf[i]       = f;
      dec.active[i]   = (i < levels);
      dec.z_order[i]  = ords[i];
      dec.rem_bits[i] = LBITS_BITS'({acc, 1'b0});
      dec.sub_log[i]  = MLOG_BITS'(regs.leaf_size_log2) + MLOG_BITS'(acc);
      if (i < levels) begin
        acc = acc + SUM_BITS'(f);
      end
    end
    dec.sum_lf    = acc;
    dec.lbits     = LBITS_BITS'({acc, 1'b0});
    dec.macro_log = MLOG_BITS'(regs.leaf_size_log2) + MLOG_BITS'(acc);
  end

endmodule
